>>> design/cwl_pkg.sv
// ----------------------------------------------------------------------------
// cwl_pkg
// Shared types, register indexes, status codes and sizes for the crop and
// window/level grayscale unit.
// ----------------------------------------------------------------------------
package cwl_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int SAMPLE_BITS = 32;
   localparam int GRAY_BITS   = 8;
   localparam int CNT_BITS    = 13;
   localparam int PROD_BITS   = SAMPLE_BITS + GRAY_BITS;
   localparam int STEP_BITS   = $clog2(GRAY_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [CNT_BITS-1:0] CNT_MAX     = {CNT_BITS{1'b1}};
   localparam logic [CNT_BITS-1:0] MAX_DIM_CNT = CNT_BITS'(MAX_DIM);

   // Register reset values.
   localparam logic [25:0] FRAME_SIZE_RST  = 26'd33558528;
   localparam logic [11:0] CROP_X_BEG_RST  = 12'd0;
   localparam logic [12:0] CROP_X_END_RST  = 13'd4096;
   localparam logic [11:0] CROP_Y_BEG_RST  = 12'd0;
   localparam logic [12:0] CROP_Y_END_RST  = 13'd4096;
   localparam logic [31:0] RANGE_LOW_RST   = 32'd0;
   localparam logic [31:0] RANGE_HIGH_RST  = 32'd16711680;

   typedef enum logic [2:0] {
      CSR_FRAME_SIZE   = 3'd0,
      CSR_CROP_X_START = 3'd1,
      CSR_CROP_X_END   = 3'd2,
      CSR_CROP_Y_START = 3'd3,
      CSR_CROP_Y_END   = 3'd4,
      CSR_RANGE_LOW    = 3'd5,
      CSR_RANGE_HIGH   = 3'd6,
      CSR_OOR_MODE     = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      OOR_CLAMP     = 2'd0,
      OOR_LOW       = 2'd1,
      OOR_HIGH      = 2'd2,
      OOR_UNUSED    = 2'd3
   } oor_mode_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ROW_LEN   = 2'd1;
   localparam logic [1:0] ST_ROW_COUNT = 2'd2;
   localparam logic [1:0] ST_BAD_CROP  = 2'd3;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_DIVIDE = 2'd1,
      BK_DONE   = 2'd2
   } back_state_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      logic                   need_div;
      logic [SAMPLE_BITS-1:0] num;
      logic [SAMPLE_BITS-1:0] den;
      logic                   valid;
      logic                   last;
      logic [1:0]             status;
   } cwl_entry_type;

endpackage

>>> design/cwl_front.sv
// ----------------------------------------------------------------------------
// cwl_front
// Configuration registers, raster position counters, error checks and the
// crop and out-of-range classification of each accepted sample.
// ----------------------------------------------------------------------------
module cwl_front
   import cwl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_row_end,
   input  logic                   req_frame_end,
   input  logic                   q_full,
   output logic                   q_push,
   output cwl_entry_type          q_wdata
);

   logic [25:0]                   frame_size_ff;
   logic [11:0]                   crop_x_beg_ff;
   logic [12:0]                   crop_x_end_ff;
   logic [11:0]                   crop_y_beg_ff;
   logic [12:0]                   crop_y_end_ff;
   logic signed [SAMPLE_BITS-1:0] range_low_ff;
   logic signed [SAMPLE_BITS-1:0] range_high_ff;
   logic [1:0]                    oor_mode_ff;

   logic [CNT_BITS-1:0] col_ff, col_in;
   logic [CNT_BITS-1:0] row_ff, row_in;
   logic                err_ff, err_in;

   logic [CNT_BITS-1:0]           width, height;
   logic                          fend, rend, bad_crop, in_window;
   logic [1:0]                    status;
   logic signed [SAMPLE_BITS-1:0] s, v;
   logic signed [SAMPLE_BITS:0]   num_wide, den_wide;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff <= FRAME_SIZE_RST;
         crop_x_beg_ff <= CROP_X_BEG_RST;
         crop_x_end_ff <= CROP_X_END_RST;
         crop_y_beg_ff <= CROP_Y_BEG_RST;
         crop_y_end_ff <= CROP_Y_END_RST;
         range_low_ff  <= RANGE_LOW_RST[SAMPLE_BITS-1:0];
         range_high_ff <= RANGE_HIGH_RST[SAMPLE_BITS-1:0];
         oor_mode_ff   <= OOR_CLAMP;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_SIZE:   frame_size_ff <= csr_data[25:0];
            CSR_CROP_X_START: crop_x_beg_ff <= csr_data[11:0];
            CSR_CROP_X_END:   crop_x_end_ff <= csr_data[12:0];
            CSR_CROP_Y_START: crop_y_beg_ff <= csr_data[11:0];
            CSR_CROP_Y_END:   crop_y_end_ff <= csr_data[12:0];
            CSR_RANGE_LOW:    range_low_ff  <= csr_data[SAMPLE_BITS-1:0];
            CSR_RANGE_HIGH:   range_high_ff <= csr_data[SAMPLE_BITS-1:0];
            CSR_OOR_MODE:     oor_mode_ff   <= csr_data[1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      width  = frame_size_ff[12:0];
      height = frame_size_ff[25:13];
      fend   = req_frame_end;
      rend   = req_row_end || req_frame_end;

      bad_crop = ({1'b0, crop_x_beg_ff} >= crop_x_end_ff) ||
                 ({1'b0, crop_y_beg_ff} >= crop_y_end_ff) ||
                 (crop_x_end_ff > width) || (crop_y_end_ff > height) ||
                 (width > MAX_DIM_CNT) || (height > MAX_DIM_CNT);

      status = ST_OK;
      if (!err_ff) begin
         if (bad_crop) begin
            status = ST_BAD_CROP;
         end else begin
            if (row_ff < height) begin
               if (rend ? (col_ff != width - 1'b1) : (col_ff >= width - 1'b1))
                  status = ST_ROW_LEN;
            end
            if (status == ST_OK && fend &&
                ({1'b0, row_ff} + 1'b1) < {1'b0, height})
               status = ST_ROW_COUNT;
         end
      end

      in_window = (col_ff >= {1'b0, crop_x_beg_ff}) && (col_ff < crop_x_end_ff) &&
                  (row_ff >= {1'b0, crop_y_beg_ff}) && (row_ff < crop_y_end_ff);

      // Out-of-range samples are limited before the mapping.
      s = req_sample;
      v = s;
      if (s < range_low_ff)
         v = (oor_mode_ff == OOR_HIGH) ? range_high_ff : range_low_ff;
      else if (s > range_high_ff)
         v = (oor_mode_ff == OOR_LOW) ? range_low_ff : range_high_ff;

      num_wide = {v[SAMPLE_BITS-1], v} - {range_low_ff[SAMPLE_BITS-1], range_low_ff};
      den_wide = {range_high_ff[SAMPLE_BITS-1], range_high_ff} -
                 {range_low_ff[SAMPLE_BITS-1], range_low_ff};

      q_wdata.valid    = !err_ff && status == ST_OK && in_window;
      q_wdata.last     = q_wdata.valid && (col_ff == crop_x_end_ff - 1'b1);
      q_wdata.status   = status;
      q_wdata.need_div = q_wdata.valid && (range_high_ff > range_low_ff);
      q_wdata.num      = num_wide[SAMPLE_BITS-1:0];
      q_wdata.den      = den_wide[SAMPLE_BITS-1:0];
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      err_in = err_ff;
      if (q_push) begin
         if (fend) begin
            col_in = '0;
            row_in = '0;
            err_in = 1'b0;
         end else begin
            if (status != ST_OK)
               err_in = 1'b1;
            if (rend) begin
               col_in = '0;
               if (row_ff < CNT_MAX)
                  row_in = row_ff + 1'b1;
            end else if (col_ff < CNT_MAX) begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         err_ff <= err_in;
      end
   end

endmodule

>>> design/cwl_queue.sv
// ----------------------------------------------------------------------------
// cwl_queue
// Short first-in first-out queue of classified items between the front and
// the back.
// ----------------------------------------------------------------------------
module cwl_queue
   import cwl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cwl_entry_type wdata,
   input  logic          pop,
   output cwl_entry_type rdata,
   output logic          full,
   output logic          nonempty
);

   cwl_entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;

   assign full     = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign nonempty = (count_ff != '0);
   assign rdata    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= wdata;
   end

endmodule

>>> design/cwl_back.sv
// ----------------------------------------------------------------------------
// cwl_back
// Gray level mapping by a one-bit-per-cycle restoring divider, and the
// result output register.
// ----------------------------------------------------------------------------
module cwl_back
   import cwl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cwl_entry_type        q_rdata,
   input  logic                 q_nonempty,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [GRAY_BITS-1:0] rsp_gray,
   output logic                 rsp_gray_valid,
   output logic                 rsp_crop_row_last,
   output logic [1:0]           rsp_status
);

   back_state_type state_ff, state_in;

   logic [STEP_BITS-1:0]   step_ff;
   logic [SAMPLE_BITS:0]   rem_ff;
   logic [GRAY_BITS-1:0]   nlow_ff;
   logic [SAMPLE_BITS-1:0] den_ff;
   logic [GRAY_BITS-1:0]   quo_ff;
   logic                   last_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [GRAY_BITS-1:0]   gray_ff;
   logic                   gray_valid_ff;
   logic                   row_last_ff;
   logic [1:0]             status_ff;

   logic                   out_free;
   logic                   load_div, load_direct, load_quo, div_step;
   logic [PROD_BITS-1:0]   prod;
   logic [SAMPLE_BITS:0]   trial;
   logic                   take;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // num * 255 as a shift and a subtract.
   assign prod  = {q_rdata.num, {GRAY_BITS{1'b0}}} -
                  {{GRAY_BITS{1'b0}}, q_rdata.num};
   assign trial = {rem_ff[SAMPLE_BITS-1:0], nlow_ff[GRAY_BITS-1]};
   assign take  = trial >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_nonempty && q_rdata.need_div)
               state_in = BK_DIVIDE;
         end
         BK_DIVIDE: begin
            if (step_ff == STEP_BITS'(GRAY_BITS - 1))
               state_in = BK_DONE;
         end
         BK_DONE: begin
            if (out_free)
               state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      load_div    = 1'b0;
      load_direct = 1'b0;
      load_quo    = 1'b0;
      div_step    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            load_div    = q_nonempty && q_rdata.need_div;
            load_direct = q_nonempty && !q_rdata.need_div && out_free;
         end
         BK_DIVIDE: div_step = 1'b1;
         BK_DONE:   load_quo = out_free;
         default:   ;
      endcase
      q_pop = load_div || load_direct;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_direct || load_quo)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_div)
            step_ff <= '0;
         else if (div_step)
            step_ff <= step_ff + 1'b1;
      end
   end

   // Quotient fits in eight bits because num never exceeds den.
   always_ff @(posedge clock) begin
      if (load_div) begin
         rem_ff  <= {1'b0, prod[PROD_BITS-1:GRAY_BITS]};
         nlow_ff <= prod[GRAY_BITS-1:0];
         den_ff  <= q_rdata.den;
         last_ff <= q_rdata.last;
         quo_ff  <= '0;
      end else if (div_step) begin
         rem_ff  <= take ? trial - {1'b0, den_ff} : trial;
         nlow_ff <= {nlow_ff[GRAY_BITS-2:0], 1'b0};
         quo_ff  <= {quo_ff[GRAY_BITS-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (load_direct) begin
         gray_ff       <= '0;
         gray_valid_ff <= q_rdata.valid;
         row_last_ff   <= q_rdata.last;
         status_ff     <= q_rdata.status;
      end else if (load_quo) begin
         gray_ff       <= quo_ff;
         gray_valid_ff <= 1'b1;
         row_last_ff   <= last_ff;
         status_ff     <= ST_OK;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gray          = gray_ff;
   assign rsp_gray_valid    = gray_valid_ff;
   assign rsp_crop_row_last = row_last_ff;
   assign rsp_status        = status_ff;

endmodule

>>> design/crop_window_level_to_gray8_unit.sv
// ----------------------------------------------------------------------------
// crop_window_level_to_gray8_unit
// Crops a raster stream of signed Q16.16 samples and maps kept samples to
// 8-bit gray levels through a value window, reporting frame errors.
// ----------------------------------------------------------------------------
// Path: a request transfer writes its item into the queue; an unmapped item
// goes straight to the response register, a mapped pixel with high above low
// through the 8-step gray divider. Throughput: 1 item per cycle for unmapped
// items while responses are taken; the divider holds the back end till done.
// Reset: synchronous; clears counters, error latch and queue, and loads the
// register defaults. Nothing needs a clearing pass.
module crop_window_level_to_gray8_unit
   import cwl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_row_end,
   input  logic                   req_frame_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [GRAY_BITS-1:0]   rsp_gray,
   output logic                   rsp_gray_valid,
   output logic                   rsp_crop_row_last,
   output logic [1:0]             rsp_status
);

   cwl_entry_type q_wdata, q_rdata;
   logic          q_push, q_pop, q_full, q_nonempty;

   cwl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_row_end   (req_row_end),
      .req_frame_end (req_frame_end),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_wdata       (q_wdata)
   );

   cwl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wdata    (q_wdata),
      .pop      (q_pop),
      .rdata    (q_rdata),
      .full     (q_full),
      .nonempty (q_nonempty)
   );

   cwl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_rdata           (q_rdata),
      .q_nonempty        (q_nonempty),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_gray          (rsp_gray),
      .rsp_gray_valid    (rsp_gray_valid),
      .rsp_crop_row_last (rsp_crop_row_last),
      .rsp_status        (rsp_status)
   );

endmodule

>>> design/cwl_checker.sv
// ----------------------------------------------------------------------------
// cwl_checker
// Port-level checks on the response stream of the grayscale unit.
// ----------------------------------------------------------------------------
module cwl_checker
   import cwl_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [GRAY_BITS-1:0] rsp_gray,
   input logic                 rsp_gray_valid,
   input logic                 rsp_crop_row_last,
   input logic [1:0]           rsp_status
);

   // A pixel that is not kept always carries gray level zero.
   a_gray_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_gray_valid |-> rsp_gray == '0)
      else $error("gray level set on a pixel that is not kept");

   a_last_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crop_row_last |-> rsp_gray_valid)
      else $error("row-last mark on a pixel that is not kept");

   a_err_no_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_gray_valid)
      else $error("kept pixel reported together with an error");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gray) &&
                                  $stable(rsp_status))
      else $error("stalled response changed before its transfer");

endmodule

bind crop_window_level_to_gray8_unit cwl_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_gray          (rsp_gray),
   .rsp_gray_valid    (rsp_gray_valid),
   .rsp_crop_row_last (rsp_crop_row_last),
   .rsp_status        (rsp_status)
);
